/* hw/rtl/qcse_pkg.sv */
package qcse_pkg;

	// Lanes per quaternion: x, y, z, w
	localparam int unsigned LANES = 4;

	// Block scaling target length of the largest magnitude
	localparam int unsigned TARGET_BITS = 30;

	// Sum of four squares of TARGET_BITS-bit values
	localparam int unsigned NORM_BITS = 2 * TARGET_BITS + 2;

	// One root bit per pair of radicand bits
	localparam int unsigned SQRT_STEPS = NORM_BITS / 2;

	// Output fraction bits (Q1.14) and quotient width (up to 16384)
	localparam int unsigned SCALE_SHIFT = 14;
	localparam int unsigned QUOT_BITS = SCALE_SHIFT + 1;

	// Configuration port geometry
	localparam int unsigned REG_AW = 5;
	localparam int unsigned REG_DW = 64;

	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	typedef enum logic [1:0] {
		REG_CONST  = 2'd0,
		REG_LINEAR = 2'd1,
		REG_SQUARE = 2'd2,
		REG_CUBE   = 2'd3
	} reg_idx_t;

endpackage

/* hw/rtl/quaternion_cubic_spline_eval_unit.sv */
// Cubic quaternion spline evaluator. Each item carries one time sample t
// (unsigned, 8 fraction bits) and yields one unit quaternion in signed Q1.14:
// the cubic a + b*t + c*t^2 + d*t^3 is evaluated exactly per component from
// the four coefficient registers (64 bits each, at byte addresses 0, 8, 16,
// 24; lanes x,y,z,w in 16-bit slices, signed Q7.8), block-scaled so the
// largest magnitude is 30 bits long, and divided by the floor square root of
// the sum of squares with rounding half away from zero. An all-zero sum
// returns zero components with zero_length set. The datapath is a fully
// pipelined chain of 57 register stages plus the output register: one item
// enters every cycle unless the output stalls. Most of the stages belong
// to the square root (one root bit per stage, 31 stages) and the division
// (one quotient bit per stage, 15 stages). When the output is not taken the
// whole pipeline holds; in_ready is high whenever the output register is
// empty or being taken. Coefficients are read live, so write them only while
// no item is in flight.
module quaternion_cubic_spline_eval_unit #(
	parameter int COMP_WIDTH = 16,
	parameter int TIME_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [qcse_pkg::REG_AW-1:0]          paddr,
	input  logic [qcse_pkg::REG_DW-1:0]          pwdata,
	output logic [qcse_pkg::REG_DW-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [TIME_WIDTH-1:0]                time_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [15:0]                   quat_x,
	output logic signed [15:0]                   quat_y,
	output logic signed [15:0]                   quat_z,
	output logic signed [15:0]                   quat_w,
	output logic                                 zero_length
);
	import qcse_pkg::*;

	// Widest power of t, scaled to 2^-32 units
	localparam int PW    = (3 * TIME_WIDTH > 24) ? 3 * TIME_WIDTH : 24;
	// Exact polynomial sum width
	localparam int SW    = COMP_WIDTH + PW + 3;
	// Coefficient times one TIME_WIDTH chunk
	localparam int PRW   = COMP_WIDTH + TIME_WIDTH + 1;
	localparam int NGRP  = (SW + 7) / 8;
	localparam int GW    = NGRP * 8;
	localparam int LW    = $clog2(SW + 1);
	localparam int RW    = SQRT_STEPS;
	localparam int REMW  = RW + 2;
	localparam int NUMW  = TARGET_BITS + SCALE_SHIFT + 1;
	localparam int TW    = TIME_WIDTH;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [REG_DW-1:0] coef_q [LANES];
	reg_idx_t          reg_idx;

	assign reg_idx = reg_idx_t'(paddr[REG_AW-1:3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				coef_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_CONST:  coef_q[0] <= pwdata;
				REG_LINEAR: coef_q[1] <= pwdata;
				REG_SQUARE: coef_q[2] <= pwdata;
				REG_CUBE:   coef_q[3] <= pwdata;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CONST:  prdata = coef_q[0];
			REG_LINEAR: prdata = coef_q[1];
			REG_SQUARE: prdata = coef_q[2];
			REG_CUBE:   prdata = coef_q[3];
			default:    prdata = '0;
		endcase
	end

	// Coefficient lanes, sign-extended from the low COMP_WIDTH bits
	logic signed [COMP_WIDTH-1:0] ca [LANES];
	logic signed [COMP_WIDTH-1:0] cb [LANES];
	logic signed [COMP_WIDTH-1:0] cc [LANES];
	logic signed [COMP_WIDTH-1:0] cd [LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign ca[l] = coef_q[0][16*l +: COMP_WIDTH];
		assign cb[l] = coef_q[1][16*l +: COMP_WIDTH];
		assign cc[l] = coef_q[2][16*l +: COMP_WIDTH];
		assign cd[l] = coef_q[3][16*l +: COMP_WIDTH];
	end

	// ------------------------------------------------------------------
	// Pipeline control: the whole chain advances unless the output stalls
	// ------------------------------------------------------------------
	localparam int FRONT  = 11;
	localparam int NSTAGE = FRONT + SQRT_STEPS + QUOT_BITS;

	logic adv;
	logic vld_s [1:NSTAGE];
	logic out_vld_q;

	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTAGE; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NSTAGE; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_vld_q <= vld_s[NSTAGE];
		end
	end

	// ------------------------------------------------------------------
	// Polynomial front end
	// ------------------------------------------------------------------
	logic [TW-1:0]            t_s1;
	logic [2*TW-1:0]          t2_s1;
	logic [2*TW-1:0]          t2_c;
	logic [2*TW-1:0]          p_lo_s2, p_hi_s2;
	logic signed [PRW-1:0]    bt_s2  [LANES];
	logic signed [PRW-1:0]    clo_s2 [LANES];
	logic signed [PRW-1:0]    chi_s2 [LANES];
	logic [3*TW-1:0]          t3_s3;
	logic signed [SW-1:0]     u_c    [LANES];
	logic signed [SW-1:0]     u_s3   [LANES];
	logic signed [PRW-1:0]    d0_s4  [LANES];
	logic signed [PRW-1:0]    d1_s4  [LANES];
	logic signed [PRW-1:0]    d2_s4  [LANES];
	logic signed [SW-1:0]     u_s4   [LANES];
	logic signed [SW-1:0]     s_s5   [LANES];
	logic [SW-1:0]            mag_s6 [LANES];
	logic [LANES-1:0]         neg_s6;
	logic [GW-1:0]            orw_c;
	logic [3:0]               glen_c [NGRP];
	logic [3:0]               glen_s7 [NGRP];
	logic [SW-1:0]            mag_s7 [LANES];
	logic [LANES-1:0]         neg_s7;
	logic [LW-1:0]            maxlen_c;
	logic [LW-1:0]            maxlen_s8;
	logic [SW-1:0]            mag_s8 [LANES];
	logic [LANES-1:0]         neg_s8;
	logic [TARGET_BITS-1:0]   v_c    [LANES];
	logic [TARGET_BITS-1:0]   v_s9   [LANES];
	logic [LANES-1:0]         neg_s9;
	logic                     zero_s9;
	logic [2*TARGET_BITS-1:0] sq_s10 [LANES];
	logic [TARGET_BITS-1:0]   v_s10  [LANES];
	logic [LANES-1:0]         neg_s10;
	logic                     zero_s10;
	logic [NORM_BITS-1:0]     n_s11;
	logic [TARGET_BITS-1:0]   v_s11  [LANES];
	logic [LANES-1:0]         neg_s11;
	logic                     zero_s11;

	assign t2_c = time_in * time_in;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			u_c[l] = (SW'(ca[l]) <<< 24) + (SW'(bt_s2[l]) <<< 16)
				+ (SW'(chi_s2[l]) <<< (TW + 8)) + (SW'(clo_s2[l]) <<< 8);
		end
	end

	// Group OR of all magnitudes: its bit length is that of the largest one
	always_comb begin
		orw_c = '0;
		for (int l = 0; l < LANES; l++) begin
			orw_c = orw_c | GW'(mag_s6[l]);
		end
		for (int g = 0; g < NGRP; g++) begin
			glen_c[g] = 4'd0;
			for (int j = 0; j < 8; j++) begin
				if (orw_c[g*8+j]) begin
					glen_c[g] = 4'(j + 1);
				end
			end
		end
	end

	always_comb begin
		maxlen_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (glen_s7[g] != 4'd0) begin
				maxlen_c = LW'(g * 8) + LW'(glen_s7[g]);
			end
		end
	end

	// Block scaling: bring the largest magnitude to TARGET_BITS bits
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (maxlen_s8 > LW'(TARGET_BITS)) begin
				v_c[l] = TARGET_BITS'(mag_s8[l] >> (maxlen_s8 - LW'(TARGET_BITS)));
			end else begin
				v_c[l] = TARGET_BITS'(mag_s8[l][TARGET_BITS-1:0]
					<< (LW'(TARGET_BITS) - maxlen_s8));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: powers of t start here
			t_s1  <= time_in;
			t2_s1 <= t2_c;
			// s2: chunked products
			p_lo_s2 <= t2_s1[TW-1:0] * t_s1;
			p_hi_s2 <= t2_s1[2*TW-1:TW] * t_s1;
			for (int l = 0; l < LANES; l++) begin
				bt_s2[l]  <= cb[l] * $signed({1'b0, t_s1});
				clo_s2[l] <= cc[l] * $signed({1'b0, t2_s1[TW-1:0]});
				chi_s2[l] <= cc[l] * $signed({1'b0, t2_s1[2*TW-1:TW]});
			end
			// s3: t^3 and the low-order partial sum
			t3_s3 <= {p_hi_s2, {TW{1'b0}}} + (3*TW)'(p_lo_s2);
			for (int l = 0; l < LANES; l++) begin
				u_s3[l] <= u_c[l];
			end
			// s4: cubic products
			for (int l = 0; l < LANES; l++) begin
				d0_s4[l] <= cd[l] * $signed({1'b0, t3_s3[TW-1:0]});
				d1_s4[l] <= cd[l] * $signed({1'b0, t3_s3[2*TW-1:TW]});
				d2_s4[l] <= cd[l] * $signed({1'b0, t3_s3[3*TW-1:2*TW]});
				u_s4[l]  <= u_s3[l];
			end
			// s5: exact sums
			for (int l = 0; l < LANES; l++) begin
				s_s5[l] <= u_s4[l] + SW'(d0_s4[l]) + (SW'(d1_s4[l]) <<< TW)
					+ (SW'(d2_s4[l]) <<< (2 * TW));
			end
			// s6: sign and magnitude
			for (int l = 0; l < LANES; l++) begin
				neg_s6[l] <= s_s5[l][SW-1];
				mag_s6[l] <= s_s5[l][SW-1] ? $unsigned(-s_s5[l]) : $unsigned(s_s5[l]);
			end
			// s7: per-group bit lengths
			glen_s7 <= glen_c;
			mag_s7  <= mag_s6;
			neg_s7  <= neg_s6;
			// s8: overall bit length
			maxlen_s8 <= maxlen_c;
			mag_s8    <= mag_s7;
			neg_s8    <= neg_s7;
			// s9: scaled magnitudes
			v_s9    <= v_c;
			neg_s9  <= neg_s8;
			zero_s9 <= (maxlen_s8 == '0);
			// s10: squares
			for (int l = 0; l < LANES; l++) begin
				sq_s10[l] <= v_s9[l] * v_s9[l];
			end
			v_s10    <= v_s9;
			neg_s10  <= neg_s9;
			zero_s10 <= zero_s9;
			// s11: sum of squares
			n_s11 <= NORM_BITS'(sq_s10[0]) + NORM_BITS'(sq_s10[1])
				+ NORM_BITS'(sq_s10[2]) + NORM_BITS'(sq_s10[3]);
			v_s11    <= v_s10;
			neg_s11  <= neg_s10;
			zero_s11 <= zero_s10;
		end
	end

	// ------------------------------------------------------------------
	// Square root: one root bit per stage
	// ------------------------------------------------------------------
	logic [REMW-1:0]        rt_rem_s  [SQRT_STEPS];
	logic [RW-1:0]          rt_root_s [SQRT_STEPS];
	logic [NORM_BITS-1:0]   rt_n_s    [SQRT_STEPS];
	logic [TARGET_BITS-1:0] rt_v_s    [SQRT_STEPS][LANES];
	logic [LANES-1:0]       rt_neg_s  [SQRT_STEPS];
	logic                   rt_zero_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [REMW-1:0]        rem_in, rem_sh, trial, rem_nx;
		logic [RW-1:0]          root_in, root_nx;
		logic [NORM_BITS-1:0]   n_in;
		logic [TARGET_BITS-1:0] v_in [LANES];
		logic [LANES-1:0]       neg_in;
		logic                   zero_in;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign n_in    = n_s11;
			assign v_in    = v_s11;
			assign neg_in  = neg_s11;
			assign zero_in = zero_s11;
		end else begin : g_next
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign n_in    = rt_n_s[k-1];
			assign v_in    = rt_v_s[k-1];
			assign neg_in  = rt_neg_s[k-1];
			assign zero_in = rt_zero_s[k-1];
		end

		always_comb begin
			rem_sh = {rem_in[REMW-3:0], n_in[NORM_BITS-1 -: 2]};
			trial  = {root_in, 2'b01};
			if (rem_sh >= trial) begin
				rem_nx  = rem_sh - trial;
				root_nx = {root_in[RW-2:0], 1'b1};
			end else begin
				rem_nx  = rem_sh;
				root_nx = {root_in[RW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[k]  <= rem_nx;
				rt_root_s[k] <= root_nx;
				rt_n_s[k]    <= {n_in[NORM_BITS-3:0], 2'b00};
				rt_v_s[k]    <= v_in;
				rt_neg_s[k]  <= neg_in;
				rt_zero_s[k] <= zero_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Division (v*16384 + r/2) / r: one quotient bit per stage, four lanes
	// ------------------------------------------------------------------
	logic [NUMW-1:0]      dv_rem_s  [QUOT_BITS][LANES];
	logic [QUOT_BITS-1:0] dv_q_s    [QUOT_BITS][LANES];
	logic [RW-1:0]        dv_den_s  [QUOT_BITS];
	logic [LANES-1:0]     dv_neg_s  [QUOT_BITS];
	logic                 dv_zero_s [QUOT_BITS];

	for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
		localparam int QB = QUOT_BITS - 1 - j;
		logic [NUMW-1:0]      rem_in [LANES];
		logic [QUOT_BITS-1:0] q_in   [LANES];
		logic [RW-1:0]        den_in;
		logic [LANES-1:0]     neg_in;
		logic                 zero_in;
		logic [NUMW-1:0]      dsh;
		logic [NUMW-1:0]      rem_nx [LANES];
		logic [QUOT_BITS-1:0] q_nx   [LANES];

		if (j == 0) begin : g_first
			localparam int LAST = SQRT_STEPS - 1;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign rem_in[l] = (NUMW'(rt_v_s[LAST][l]) << SCALE_SHIFT)
					+ NUMW'(rt_root_s[LAST] >> 1);
				assign q_in[l]   = '0;
			end
			assign den_in  = rt_root_s[LAST];
			assign neg_in  = rt_neg_s[LAST];
			assign zero_in = rt_zero_s[LAST];
		end else begin : g_next
			assign rem_in  = dv_rem_s[j-1];
			assign q_in    = dv_q_s[j-1];
			assign den_in  = dv_den_s[j-1];
			assign neg_in  = dv_neg_s[j-1];
			assign zero_in = dv_zero_s[j-1];
		end

		assign dsh = NUMW'(den_in) << QB;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (rem_in[l] >= dsh) begin
					rem_nx[l] = rem_in[l] - dsh;
					q_nx[l]   = {q_in[l][QUOT_BITS-2:0], 1'b1};
				end else begin
					rem_nx[l] = rem_in[l];
					q_nx[l]   = {q_in[l][QUOT_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j]  <= rem_nx;
				dv_q_s[j]    <= q_nx;
				dv_den_s[j]  <= den_in;
				dv_neg_s[j]  <= neg_in;
				dv_zero_s[j] <= zero_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: apply signs, force zero on a zero-length sum
	// ------------------------------------------------------------------
	localparam int DL = QUOT_BITS - 1;

	logic signed [15:0] comp_c [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dv_zero_s[DL]) begin
				comp_c[l] = '0;
			end else if (dv_neg_s[DL][l]) begin
				comp_c[l] = -$signed(16'(dv_q_s[DL][l]));
			end else begin
				comp_c[l] = $signed(16'(dv_q_s[DL][l]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_x      <= comp_c[0];
			quat_y      <= comp_c[1];
			quat_z      <= comp_c[2];
			quat_w      <= comp_c[3];
			zero_length <= dv_zero_s[DL];
		end
	end

endmodule

/* hw/rtl/qcse_check.sv */
module qcse_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic signed [15:0] quat_w,
	input logic               zero_length
);
	import qcse_pkg::*;

	// An empty output register never blocks a new item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_y)
			&& $stable(quat_z) && $stable(quat_w) && $stable(zero_length))
		else $error("stalled result changed");

	// Zero-length sums give zero components
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> quat_x == 0 && quat_y == 0 && quat_z == 0
			&& quat_w == 0)
		else $error("zero_length with nonzero component");

	// Unit-length components stay within one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_x <= Q14_ONE && quat_x >= -Q14_ONE
			&& quat_y <= Q14_ONE && quat_y >= -Q14_ONE
			&& quat_z <= Q14_ONE && quat_z >= -Q14_ONE
			&& quat_w <= Q14_ONE && quat_w >= -Q14_ONE)
		else $error("component out of range");

endmodule

bind quaternion_cubic_spline_eval_unit qcse_check u_qcse_check (.*);
